>>> design/wmed_pkg.sv
// Package for the window median block: sample and count widths, default
// window depth, and the input and result item types.
// No dependencies.
`default_nettype none

package wmed_pkg;

  localparam int SAMPLE_BITS        = 16;
  localparam int COUNT_BITS         = 6;
  localparam int WINDOW_MAX_DEFAULT = 32;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] median_value;
    logic [COUNT_BITS-1:0]         window_count;
    logic                          overflow;
  } out_item_t;

endpackage

`default_nettype wire

>>> design/wmed_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module wmed_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/window_median.sv
// Top level of the window median block: sample memory, load logic and the
// rank-counting selection sequencer.
// Depends on wmed_pkg and wmed_ram.
`default_nettype none

// window_median collects a window of signed samples, one per input transfer,
// into a sample memory of WINDOW_MAX entries, and on the transfer flagged
// last returns one result: the median of the stored samples, the number of
// samples used and a flag telling whether samples were dropped because the
// memory was full (a dropped sample is simply not stored, the closing one
// included). For an even count the median is the two middle samples summed
// and halved, truncated toward zero. A sample that does not close a window
// is taken without leaving the idle state, so samples may stream back to
// back. The closing transfer starts a selection pass over the window, plus
// any time spent waiting for an earlier result to be
// taken, during which ready stays low: for each stored sample the
// sequencer reads every stored sample once through the single read port of
// the memory, counting how many are smaller and how many are equal, which
// gives that sample's rank; the samples whose ranks match the middle
// positions are kept. The result waits in an output register, and new
// samples are accepted while it waits to be taken. There is no clearing
// pass after reset: the memory is only read below the current fill count.

module window_median #(
  parameter int WINDOW_MAX = wmed_pkg::WINDOW_MAX_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire wmed_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output wmed_pkg::out_item_t      out_item
);

  import wmed_pkg::*;

  localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int SB    = SAMPLE_BITS;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOADI = 3'd1;
  localparam logic [2:0] S_HOLDI = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]           state;
  logic [CNT_W-1:0]     fill_count;
  logic                 dropped;
  logic [AW-1:0]        idx_i;
  logic [AW-1:0]        idx_j;
  logic signed [SB-1:0] cand;
  logic [CNT_W-1:0]     cnt_lt;
  logic [CNT_W-1:0]     cnt_eq;
  logic signed [SB-1:0] mid_lo;
  logic signed [SB-1:0] mid_hi;

  logic                 in_xfer;
  logic                 room;
  logic                 ram_we;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [SB-1:0]        ram_rdata;
  logic signed [SB-1:0] rd_sample;

  logic [CNT_W-1:0]     last_idx;
  logic [CNT_W-1:0]     rank_lo;
  logic [CNT_W-1:0]     rank_hi;
  logic [CNT_W:0]       rank_top;
  logic                 hit_lo;
  logic                 hit_hi;

  logic signed [SB:0]   pair_sum;
  logic signed [SB:0]   pair_adj;
  logic                 out_free;

  // A sample transfer is taken only while the sequencer is idle. The result
  // register is separate, so a pending result does not block loading.
  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign room     = (fill_count < CNT_W'(WINDOW_MAX));
  assign ram_we   = in_xfer && room;

  assign last_idx = fill_count - CNT_W'(1);
  // Zero-based positions of the two middle samples; equal for odd counts.
  assign rank_lo  = last_idx >> 1;
  assign rank_hi  = fill_count >> 1;
  assign rank_top = {1'b0, cnt_lt} + {1'b0, cnt_eq};
  // The candidate occupies sorted positions cnt_lt .. cnt_lt + cnt_eq - 1.
  assign hit_lo   = (cnt_lt <= rank_lo) && ({1'b0, rank_lo} < rank_top);
  assign hit_hi   = (cnt_lt <= rank_hi) && ({1'b0, rank_hi} < rank_top);

  assign rd_sample = $signed(ram_rdata);

  // Read address: the candidate is fetched in LOADI or EVAL, then every
  // stored sample is streamed past it from HOLDI on.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx_i;
    unique case (state)
      S_LOADI: begin
        ram_re    = 1'b1;
        ram_raddr = idx_i;
      end
      S_HOLDI: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      S_SCAN: begin
        ram_re    = (CNT_W'(idx_j) != last_idx);
        ram_raddr = idx_j + AW'(1);
      end
      S_EVAL: begin
        ram_re    = (CNT_W'(idx_i) != last_idx);
        ram_raddr = idx_i + AW'(1);
      end
      default: begin
        ram_re    = 1'b0;
        ram_raddr = idx_i;
      end
    endcase
  end

  wmed_ram #(
    .WIDTH (SB),
    .DEPTH (WINDOW_MAX),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_count[AW-1:0]),
    .wdata (in_item.sample),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Average of the middle pair, truncated toward zero: add one to a
  // negative sum before the arithmetic halving.
  assign pair_sum = {mid_lo[SB-1], mid_lo} + {mid_hi[SB-1], mid_hi};
  assign pair_adj = pair_sum + (SB+1)'(pair_sum[SB]);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      dropped    <= 1'b0;
      out_valid  <= 1'b0;
      idx_i      <= '0;
      idx_j      <= '0;
      cnt_lt     <= '0;
      cnt_eq     <= '0;
    end else begin
      // The result register fills when the sequencer finishes and it is
      // free; otherwise a taken result empties it.
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (room) begin
              fill_count <= fill_count + CNT_W'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (in_item.last) begin
              idx_i <= '0;
              state <= S_LOADI;
            end
          end
        end
        S_LOADI: begin
          state <= S_HOLDI;
        end
        S_HOLDI: begin
          cand   <= rd_sample;
          idx_j  <= '0;
          cnt_lt <= '0;
          cnt_eq <= '0;
          state  <= S_SCAN;
        end
        S_SCAN: begin
          if (rd_sample < cand) begin
            cnt_lt <= cnt_lt + CNT_W'(1);
          end
          if (rd_sample == cand) begin
            cnt_eq <= cnt_eq + CNT_W'(1);
          end
          if (CNT_W'(idx_j) == last_idx) begin
            state <= S_EVAL;
          end else begin
            idx_j <= idx_j + AW'(1);
          end
        end
        S_EVAL: begin
          if (hit_lo) begin
            mid_lo <= cand;
          end
          if (hit_hi) begin
            mid_hi <= cand;
          end
          if (CNT_W'(idx_i) == last_idx) begin
            state <= S_DONE;
          end else begin
            idx_i <= idx_i + AW'(1);
            state <= S_HOLDI;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_item.median_value   <= pair_adj[SB:1];
            out_item.window_count   <= COUNT_BITS'(fill_count);
            out_item.overflow       <= dropped;
            fill_count              <= '0;
            dropped                 <= 1'b0;
            state                   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/wmed_checker.sv
// Port-level checker for window_median, and the bind that attaches it.
// Depends on wmed_pkg and window_median.
`default_nettype none

module wmed_props #(
  parameter int WINDOW_MAX = wmed_pkg::WINDOW_MAX_DEFAULT
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire wmed_pkg::in_item_t  in_item,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire wmed_pkg::out_item_t out_item
);

  import wmed_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Closing a window starts the selection pass, so no sample is taken next.
  a_close_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_item.last |=> !in_ready)
    else $error("sample taken right after window close");

  // A new result only comes out of a selection pass.
  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a selection pass");

  // Dropping only happens once the memory is full.
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.overflow |-> out_item.window_count == COUNT_BITS'(WINDOW_MAX))
    else $error("overflow flagged below capacity");

endmodule

bind window_median wmed_props #(
  .WINDOW_MAX (WINDOW_MAX)
) u_wmed_props (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire
